// ===== rtl/bfhp_pkg.sv =====
`timescale 1ns / 1ps
package bfhp_pkg;

	localparam int unsigned PREAMBLE_LEN = 13;
	localparam int unsigned CFG_IDX_W    = 1;
	localparam int unsigned CFG_DATA_W   = 16;

	localparam logic [7:0] SEC_A = 8'h61;
	localparam logic [7:0] SEC_D = 8'h64;
	localparam logic [7:0] SEC_E = 8'h65;

	localparam logic        REVERSE_BITS_RST   = 1'b1;
	localparam logic [15:0] MAX_STRING_LEN_RST = 16'd500;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REVERSE_BITS   = 1'b0,
		REG_MAX_STRING_LEN = 1'b1
	} reg_idx_t;

	typedef enum logic [8:0] {
		PH_PREAMBLE = 9'b000000001,
		PH_SECTION  = 9'b000000010,
		PH_SLEN_HI  = 9'b000000100,
		PH_SLEN_LO  = 9'b000001000,
		PH_SDATA    = 9'b000010000,
		PH_ELEN     = 9'b000100000,
		PH_PAYLOAD  = 9'b001000000,
		PH_DONE     = 9'b010000000,
		PH_ERROR    = 9'b100000000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_HEADER  = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE         = 3'd0,
		ERR_PREAMBLE     = 3'd1,
		ERR_SECTION      = 3'd2,
		ERR_STRING_LEN   = 3'd3,
		ERR_UNTERMINATED = 3'd4,
		ERR_TOO_LARGE    = 3'd5
	} err_t;

	typedef struct packed {
		phase_t      phase;
		logic [3:0]  preamble_index;
		logic [15:0] string_length;
		logic [15:0] string_count;
		logic [31:0] length_acc;
		logic [1:0]  length_byte_index;
		logic [30:0] bytes_remaining;
	} parse_state_t;

	typedef struct packed {
		logic        reverse_bits;
		logic [15:0] max_string_len;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  out_byte;
		logic [30:0] payload_length;
		err_t        error_code;
		logic        last_flag;
	} result_t;

	localparam parse_state_t PARSE_STATE_RST = '{
		phase:             PH_PREAMBLE,
		preamble_index:    4'd0,
		string_length:     16'd0,
		string_count:      16'd0,
		length_acc:        32'd0,
		length_byte_index: 2'd0,
		bytes_remaining:   31'd0
	};

	function automatic logic [7:0] preamble_byte(input logic [3:0] idx);
		logic [7:0] v;
		case (idx)
			4'd0:    v = 8'd0;
			4'd1:    v = 8'd9;
			4'd2:    v = 8'd15;
			4'd3:    v = 8'd240;
			4'd4:    v = 8'd15;
			4'd5:    v = 8'd240;
			4'd6:    v = 8'd15;
			4'd7:    v = 8'd240;
			4'd8:    v = 8'd15;
			4'd9:    v = 8'd240;
			4'd10:   v = 8'd0;
			4'd11:   v = 8'd0;
			4'd12:   v = 8'd1;
			default: v = 8'd0;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] flip_byte(input logic [7:0] b);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = b[7-i];
		end
		return r;
	endfunction

endpackage

// ===== rtl/bfhp_step.sv =====
`timescale 1ns / 1ps
// Per-byte parser step: next state and optional result from the current state.
module bfhp_step (
	input  bfhp_pkg::parse_state_t state,
	input  bfhp_pkg::cfg_t         cfg,
	input  logic [7:0]             in_byte,
	input  logic                   file_start,
	output bfhp_pkg::parse_state_t next_state,
	output logic                   has_result,
	output bfhp_pkg::result_t      result
);

	bfhp_pkg::parse_state_t cur;
	logic [15:0]            slen;
	logic [15:0]            scount;
	logic [31:0]            acc;
	logic [30:0]            rem_dec;

	always_comb begin
		cur     = file_start ? bfhp_pkg::PARSE_STATE_RST : state;
		slen    = {cur.string_length[15:8], in_byte};
		scount  = cur.string_count + 16'd1;
		acc     = {cur.length_acc[23:0], in_byte};
		rem_dec = cur.bytes_remaining - 31'd1;

		next_state = cur;
		has_result = 1'b0;
		result     = '{kind: bfhp_pkg::KIND_ERROR, out_byte: 8'd0, payload_length: 31'd0,
			error_code: bfhp_pkg::ERR_NONE, last_flag: 1'b0};

		case (cur.phase)
			bfhp_pkg::PH_PREAMBLE: begin
				if (cur.preamble_index >= 4'(bfhp_pkg::PREAMBLE_LEN) ||
					in_byte != bfhp_pkg::preamble_byte(cur.preamble_index)) begin
					next_state.phase  = bfhp_pkg::PH_ERROR;
					has_result        = 1'b1;
					result.error_code = bfhp_pkg::ERR_PREAMBLE;
				end else begin
					next_state.preamble_index = cur.preamble_index + 4'd1;
					if (cur.preamble_index == 4'(bfhp_pkg::PREAMBLE_LEN - 1)) begin
						next_state.phase = bfhp_pkg::PH_SECTION;
					end
				end
			end
			bfhp_pkg::PH_SECTION: begin
				if (in_byte inside {[bfhp_pkg::SEC_A:bfhp_pkg::SEC_D]}) begin
					next_state.phase = bfhp_pkg::PH_SLEN_HI;
				end else if (in_byte == bfhp_pkg::SEC_E) begin
					next_state.length_acc        = 32'd0;
					next_state.length_byte_index = 2'd0;
					next_state.phase             = bfhp_pkg::PH_ELEN;
				end else begin
					next_state.phase  = bfhp_pkg::PH_ERROR;
					has_result        = 1'b1;
					result.error_code = bfhp_pkg::ERR_SECTION;
				end
			end
			bfhp_pkg::PH_SLEN_HI: begin
				next_state.string_length = {in_byte, 8'd0};
				next_state.phase         = bfhp_pkg::PH_SLEN_LO;
			end
			bfhp_pkg::PH_SLEN_LO: begin
				next_state.string_length = slen;
				if (slen == 16'd0 || slen > cfg.max_string_len) begin
					next_state.phase  = bfhp_pkg::PH_ERROR;
					has_result        = 1'b1;
					result.error_code = bfhp_pkg::ERR_STRING_LEN;
				end else begin
					next_state.string_count = 16'd0;
					next_state.phase        = bfhp_pkg::PH_SDATA;
				end
			end
			bfhp_pkg::PH_SDATA: begin
				next_state.string_count = scount;
				if (scount == cur.string_length) begin
					if (in_byte != 8'd0) begin
						next_state.phase  = bfhp_pkg::PH_ERROR;
						has_result        = 1'b1;
						result.error_code = bfhp_pkg::ERR_UNTERMINATED;
					end else begin
						next_state.phase = bfhp_pkg::PH_SECTION;
					end
				end
			end
			bfhp_pkg::PH_ELEN: begin
				next_state.length_acc = acc;
				if (cur.length_byte_index != 2'd3) begin
					next_state.length_byte_index = cur.length_byte_index + 2'd1;
				end else begin
					next_state.length_byte_index = 2'd0;
					has_result                   = 1'b1;
					if (acc[31]) begin
						next_state.phase  = bfhp_pkg::PH_ERROR;
						result.error_code = bfhp_pkg::ERR_TOO_LARGE;
					end else begin
						next_state.bytes_remaining = acc[30:0];
						result.kind                = bfhp_pkg::KIND_HEADER;
						result.payload_length      = acc[30:0];
						result.last_flag           = (acc[30:0] == 31'd0);
						next_state.phase           = (acc[30:0] == 31'd0) ?
							bfhp_pkg::PH_DONE : bfhp_pkg::PH_PAYLOAD;
					end
				end
			end
			bfhp_pkg::PH_PAYLOAD: begin
				if (cur.bytes_remaining == 31'd0) begin
					next_state.phase = bfhp_pkg::PH_DONE;
				end else begin
					next_state.bytes_remaining = rem_dec;
					has_result                 = 1'b1;
					result.kind                = bfhp_pkg::KIND_PAYLOAD;
					result.out_byte            = cfg.reverse_bits ?
						bfhp_pkg::flip_byte(in_byte) : in_byte;
					result.last_flag           = (rem_dec == 31'd0);
					if (rem_dec == 31'd0) begin
						next_state.phase = bfhp_pkg::PH_DONE;
					end
				end
			end
			default: begin
				// done or error: drop bytes until a new file starts
			end
		endcase
	end

endmodule

// ===== rtl/bfhp_outq.sv =====
`timescale 1ns / 1ps
// Two-entry result queue; full throughput without a ready path to the input.
module bfhp_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bfhp_pkg::result_t push_data,
	output logic              full,
	output logic              out_valid,
	input  logic              out_ready,
	output bfhp_pkg::result_t out_data
);

	bfhp_pkg::result_t mem_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              pop;

	assign full      = (count_q == 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/bitstream_file_header_parser_core.sv =====
`timescale 1ns / 1ps
// Configuration file header parser with payload pass-through.
// Input channel (in_valid/in_ready): one file byte per beat, file_start set on
//   the first byte of a file restarts the parser before that byte is handled.
// Output channel (out_valid/out_ready): zero or one result per input byte:
//   kind payload (out_byte, last_flag), header complete (payload_length,
//   last_flag when the length is zero) or error (error_code). After an error
//   or after the last payload byte, bytes are dropped until file_start.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index 0 writes
//   reverse_bits, 1 writes max_string_len (low 16 bits of cfg_data). Write
//   only while no bytes are in flight.
// Path: an input beat is taken into the input register, then its parse step
//   result is written into the result queue, which drives out_valid.
// Throughput: one byte per cycle, set by the combinational parse step; the
//   two-entry result queue keeps in_ready free of any out_ready path.
// Stall: while the queue is full, a byte that would produce a result waits in
//   the input register and in_ready drops; bytes with no result still drain.
// Reset: arst_n clears the parser to the preamble phase, empties the queue
//   and loads reverse_bits=1, max_string_len=500.
module bitstream_file_header_parser_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// byte input
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [7:0]                         in_byte,
	input  logic                               file_start,
	// results
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         kind,
	output logic [7:0]                         out_byte,
	output logic [30:0]                        payload_length,
	output logic [2:0]                         error_code,
	output logic                               last_flag,
	// register writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bfhp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bfhp_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// input register
	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   start_s1;

	// parser state and registers
	bfhp_pkg::parse_state_t state_q;
	bfhp_pkg::parse_state_t next_state;
	bfhp_pkg::cfg_t         cfg_q;

	logic                   has_result;
	bfhp_pkg::result_t      step_result;
	bfhp_pkg::result_t      q_result;
	logic                   q_full;
	logic                   advance;
	logic                   fire_s1;

	assign cfg_ready = 1'b1;

	// A byte leaves the input register when it makes no result or the queue has room.
	assign advance  = !has_result || !q_full;
	assign fire_s1  = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= in_byte;
			start_s1 <= file_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfhp_pkg::PARSE_STATE_RST;
		end else if (fire_s1) begin
			state_q <= next_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reverse_bits   <= bfhp_pkg::REVERSE_BITS_RST;
			cfg_q.max_string_len <= bfhp_pkg::MAX_STRING_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bfhp_pkg::REG_REVERSE_BITS:   cfg_q.reverse_bits   <= cfg_data[0];
				bfhp_pkg::REG_MAX_STRING_LEN: cfg_q.max_string_len <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	bfhp_step u_step (
		.state      (state_q),
		.cfg        (cfg_q),
		.in_byte    (byte_s1),
		.file_start (start_s1),
		.next_state (next_state),
		.has_result (has_result),
		.result     (step_result)
	);

	bfhp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire_s1 && has_result),
		.push_data (step_result),
		.full      (q_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (q_result)
	);

	assign kind           = q_result.kind;
	assign out_byte       = q_result.out_byte;
	assign payload_length = q_result.payload_length;
	assign error_code     = q_result.error_code;
	assign last_flag      = q_result.last_flag;

endmodule
